>>> design/sct_pkg.sv
// Shared constants, codes and controller/datapath handshake types for the sorted child table.
`default_nettype none

package sct_pkg;

    localparam int CAPACITY    = 16;
    localparam int HANDLE_BITS = 48;
    localparam int KEY_BITS    = 8;
    localparam int COUNT_BITS  = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        FN_INSERT  = 2'd0,
        FN_LOOKUP  = 2'd1,
        FN_REPLACE = 2'd2,
        FN_SCAN    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_FIND,
        S_SCAN,
        S_DONE
    } t_state;

    // Read address selection for the entry RAM.
    typedef enum logic [2:0] {
        RD_TOP,
        RD_ZERO,
        RD_INC,
        RD_DEC1,
        RD_DEC2
    } t_rd_sel;

    // Write data selection: move the entry just read, or store the request pair.
    typedef enum logic {
        WR_SHIFT,
        WR_NEW
    } t_wr_sel;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_COUNT,
        IDX_TOP,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC
    } t_idx_op;

    typedef enum logic [1:0] {
        PEND_HOLD,
        PEND_CLEAR,
        PEND_TAKE,
        PEND_NEW
    } t_pend_op;

    typedef struct packed {
        logic     load;
        t_idx_op  idx_op;
        logic     rd_en;
        t_rd_sel  rd_sel;
        logic     wr_en;
        t_wr_sel  wr_sel;
        logic     cnt_inc;
        t_pend_op pend_op;
        logic     st_load;
        t_status  st_val;
        logic     emit;
        logic     emit_last;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic count_zero;
        logic idx_zero;
        logic idx_one;
        logic idx_last;
        logic key_ge;
        logic key_eq;
        logic below_lo;
        logic above_hi;
        logic pend_valid;
        logic out_free;
        logic is_replace;
    } t_stat;

endpackage

`default_nettype wire

>>> design/sct_if.sv
// Request and result channel interfaces of the sorted child table.
`default_nettype none

interface sct_req_if #(
    parameter int HANDLE_BITS = sct_pkg::HANDLE_BITS
);
    logic                              valid;
    logic                              ready;
    logic [1:0]                        func;
    logic [sct_pkg::KEY_BITS-1:0]      key_in;
    logic [HANDLE_BITS-1:0]            child_handle;
    logic [sct_pkg::KEY_BITS-1:0]      range_low;
    logic [sct_pkg::KEY_BITS-1:0]      range_high;

    modport source (
        output valid, func, key_in, child_handle, range_low, range_high,
        input  ready
    );
    modport sink (
        input  valid, func, key_in, child_handle, range_low, range_high,
        output ready
    );
endinterface

interface sct_rsp_if #(
    parameter int HANDLE_BITS = sct_pkg::HANDLE_BITS,
    parameter int COUNT_BITS  = sct_pkg::COUNT_BITS
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic                         match_valid;
    logic [sct_pkg::KEY_BITS-1:0] key_out;
    logic [HANDLE_BITS-1:0]       child_out;
    logic                         last;
    logic [COUNT_BITS-1:0]        entry_count;
    logic                         is_full;

    modport source (
        output valid, status, match_valid, key_out, child_out, last, entry_count, is_full,
        input  ready
    );
    modport sink (
        input  valid, status, match_valid, key_out, child_out, last, entry_count, is_full,
        output ready
    );
endinterface

`default_nettype wire

>>> design/sct_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module sct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> design/sct_ctrl.sv
// Controller state machine that sequences insert, lookup, replace and range scan.
`default_nettype none

module sct_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  logic [1:0]    i_req_func,
    output logic          o_req_ready,
    output sct_pkg::t_cmd o_cmd,
    input  sct_pkg::t_stat i_stat
);

    sct_pkg::t_state r_state;
    sct_pkg::t_state n_state;
    sct_pkg::t_cmd   w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sct_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_req_ready     = 1'b0;
        w_cmd           = '0;
        w_cmd.idx_op    = sct_pkg::IDX_HOLD;
        w_cmd.rd_sel    = sct_pkg::RD_TOP;
        w_cmd.wr_sel    = sct_pkg::WR_NEW;
        w_cmd.pend_op   = sct_pkg::PEND_HOLD;
        w_cmd.st_val    = sct_pkg::ST_OK;

        unique case (r_state)
            sct_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    w_cmd.load = 1'b1;
                    unique case (sct_pkg::t_func'(i_req_func))
                        sct_pkg::FN_INSERT: begin
                            if (i_stat.full) begin
                                w_cmd.pend_op = sct_pkg::PEND_CLEAR;
                                w_cmd.st_load = 1'b1;
                                w_cmd.st_val  = sct_pkg::ST_FULL;
                                n_state       = sct_pkg::S_DONE;
                            end else begin
                                w_cmd.idx_op = sct_pkg::IDX_COUNT;
                                w_cmd.rd_en  = !i_stat.count_zero;
                                w_cmd.rd_sel = sct_pkg::RD_TOP;
                                n_state      = sct_pkg::S_INS;
                            end
                        end
                        sct_pkg::FN_LOOKUP, sct_pkg::FN_REPLACE: begin
                            if (i_stat.count_zero) begin
                                w_cmd.pend_op = sct_pkg::PEND_CLEAR;
                                w_cmd.st_load = 1'b1;
                                w_cmd.st_val  = sct_pkg::ST_NOT_FOUND;
                                n_state       = sct_pkg::S_DONE;
                            end else begin
                                w_cmd.idx_op = sct_pkg::IDX_ZERO;
                                w_cmd.rd_en  = 1'b1;
                                w_cmd.rd_sel = sct_pkg::RD_ZERO;
                                n_state      = sct_pkg::S_FIND;
                            end
                        end
                        sct_pkg::FN_SCAN: begin
                            w_cmd.pend_op = sct_pkg::PEND_CLEAR;
                            w_cmd.st_load = 1'b1;
                            w_cmd.st_val  = sct_pkg::ST_OK;
                            if (i_stat.count_zero) begin
                                n_state = sct_pkg::S_DONE;
                            end else begin
                                w_cmd.idx_op = sct_pkg::IDX_TOP;
                                w_cmd.rd_en  = 1'b1;
                                w_cmd.rd_sel = sct_pkg::RD_TOP;
                                n_state      = sct_pkg::S_SCAN;
                            end
                        end
                    endcase
                end
            end

            // The index is the target slot; the RAM holds the entry just below it.
            sct_pkg::S_INS: begin
                w_cmd.wr_en = 1'b1;
                if (i_stat.idx_zero || !i_stat.key_ge) begin
                    w_cmd.wr_sel  = sct_pkg::WR_NEW;
                    w_cmd.cnt_inc = 1'b1;
                    w_cmd.pend_op = sct_pkg::PEND_CLEAR;
                    w_cmd.st_load = 1'b1;
                    w_cmd.st_val  = sct_pkg::ST_OK;
                    n_state       = sct_pkg::S_DONE;
                end else begin
                    w_cmd.wr_sel = sct_pkg::WR_SHIFT;
                    w_cmd.idx_op = sct_pkg::IDX_DEC;
                    w_cmd.rd_en  = !i_stat.idx_one;
                    w_cmd.rd_sel = sct_pkg::RD_DEC2;
                end
            end

            sct_pkg::S_FIND: begin
                if (i_stat.key_eq) begin
                    w_cmd.st_load = 1'b1;
                    w_cmd.st_val  = sct_pkg::ST_OK;
                    if (i_stat.is_replace) begin
                        w_cmd.wr_en   = 1'b1;
                        w_cmd.wr_sel  = sct_pkg::WR_NEW;
                        w_cmd.pend_op = sct_pkg::PEND_NEW;
                    end else begin
                        w_cmd.pend_op = sct_pkg::PEND_TAKE;
                    end
                    n_state = sct_pkg::S_DONE;
                end else if (i_stat.idx_last) begin
                    w_cmd.pend_op = sct_pkg::PEND_CLEAR;
                    w_cmd.st_load = 1'b1;
                    w_cmd.st_val  = sct_pkg::ST_NOT_FOUND;
                    n_state       = sct_pkg::S_DONE;
                end else begin
                    w_cmd.idx_op = sct_pkg::IDX_INC;
                    w_cmd.rd_en  = 1'b1;
                    w_cmd.rd_sel = sct_pkg::RD_INC;
                end
            end

            // A matching entry waits in the pending register until the next one
            // shows whether it is the final result.
            sct_pkg::S_SCAN: begin
                if (i_stat.below_lo) begin
                    n_state = sct_pkg::S_DONE;
                end else if (!i_stat.above_hi && i_stat.pend_valid && !i_stat.out_free) begin
                    n_state = sct_pkg::S_SCAN;
                end else begin
                    if (!i_stat.above_hi) begin
                        w_cmd.emit      = i_stat.pend_valid;
                        w_cmd.emit_last = 1'b0;
                        w_cmd.pend_op   = sct_pkg::PEND_TAKE;
                    end
                    if (i_stat.idx_zero) begin
                        n_state = sct_pkg::S_DONE;
                    end else begin
                        w_cmd.idx_op = sct_pkg::IDX_DEC;
                        w_cmd.rd_en  = 1'b1;
                        w_cmd.rd_sel = sct_pkg::RD_DEC1;
                    end
                end
            end

            sct_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    w_cmd.emit      = 1'b1;
                    w_cmd.emit_last = 1'b1;
                    n_state         = sct_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = sct_pkg::S_IDLE;
            end
        endcase
    end

    assign o_cmd = w_cmd;

endmodule

`default_nettype wire

>>> design/sct_datapath.sv
// Datapath: request registers, slot index, entry count, entry RAM and result register.
`default_nettype none

module sct_datapath #(
    parameter int CAPACITY    = sct_pkg::CAPACITY,
    parameter int HANDLE_BITS = sct_pkg::HANDLE_BITS,
    localparam int CW         = $clog2(CAPACITY + 1),
    localparam int IW         = $clog2(CAPACITY),
    localparam int KB         = sct_pkg::KEY_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sct_pkg::t_cmd          i_cmd,
    output sct_pkg::t_stat         o_stat,
    input  logic [1:0]             i_func,
    input  logic [KB-1:0]          i_key,
    input  logic [HANDLE_BITS-1:0] i_child,
    input  logic [KB-1:0]          i_lo,
    input  logic [KB-1:0]          i_hi,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [1:0]             o_status,
    output logic                   o_match,
    output logic [KB-1:0]          o_key,
    output logic [HANDLE_BITS-1:0] o_child,
    output logic                   o_last,
    output logic [CW-1:0]          o_count,
    output logic                   o_full
);

    localparam int DW = KB + HANDLE_BITS;

    sct_pkg::t_func   r_func;
    logic [KB-1:0]    r_key;
    logic [HANDLE_BITS-1:0] r_child;
    logic [KB-1:0]    r_lo;
    logic [KB-1:0]    r_hi;
    logic [IW-1:0]    r_idx;
    logic [IW-1:0]    n_idx;
    logic [CW-1:0]    r_count;
    sct_pkg::t_status r_status;
    logic             r_pend_valid;
    logic [DW-1:0]    r_pend;
    logic             n_pend_valid;
    logic [DW-1:0]    n_pend;

    logic             r_o_valid;
    sct_pkg::t_status r_o_status;
    logic             r_o_match;
    logic [KB-1:0]    r_o_key;
    logic [HANDLE_BITS-1:0] r_o_child;
    logic             r_o_last;
    logic [CW-1:0]    r_o_count;
    logic             r_o_full;

    logic [CW-1:0]    w_cnt_m1;
    logic [IW-1:0]    w_rd_addr;
    logic [DW-1:0]    w_wr_data;
    logic [DW-1:0]    w_rd_data;
    logic [KB-1:0]    w_rd_key;
    logic             w_out_free;
    logic             w_full;

    assign w_cnt_m1   = r_count - CW'(1);
    assign w_rd_key   = w_rd_data[DW-1:HANDLE_BITS];
    assign w_out_free = !r_o_valid || i_out_ready;
    assign w_full     = (r_count >= CW'(CAPACITY));
    assign w_wr_data  = (i_cmd.wr_sel == sct_pkg::WR_SHIFT) ? w_rd_data : {r_key, r_child};

    always_comb begin
        unique case (i_cmd.rd_sel)
            sct_pkg::RD_TOP:  w_rd_addr = w_cnt_m1[IW-1:0];
            sct_pkg::RD_ZERO: w_rd_addr = '0;
            sct_pkg::RD_INC:  w_rd_addr = r_idx + IW'(1);
            sct_pkg::RD_DEC1: w_rd_addr = r_idx - IW'(1);
            sct_pkg::RD_DEC2: w_rd_addr = r_idx - IW'(2);
            default:          w_rd_addr = '0;
        endcase
    end

    always_comb begin
        unique case (i_cmd.idx_op)
            sct_pkg::IDX_HOLD:  n_idx = r_idx;
            sct_pkg::IDX_COUNT: n_idx = r_count[IW-1:0];
            sct_pkg::IDX_TOP:   n_idx = w_cnt_m1[IW-1:0];
            sct_pkg::IDX_ZERO:  n_idx = '0;
            sct_pkg::IDX_INC:   n_idx = r_idx + IW'(1);
            sct_pkg::IDX_DEC:   n_idx = r_idx - IW'(1);
            default:            n_idx = r_idx;
        endcase
    end

    always_comb begin
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        unique case (i_cmd.pend_op)
            sct_pkg::PEND_HOLD: begin
            end
            sct_pkg::PEND_CLEAR: begin
                n_pend_valid = 1'b0;
            end
            sct_pkg::PEND_TAKE: begin
                n_pend_valid = 1'b1;
                n_pend       = w_rd_data;
            end
            sct_pkg::PEND_NEW: begin
                n_pend_valid = 1'b1;
                n_pend       = {r_key, r_child};
            end
            default: begin
            end
        endcase
    end

    sct_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_entries (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (r_idx),
        .i_wr_data (w_wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= sct_pkg::t_func'(i_func);
            r_key   <= i_key;
            r_child <= i_child;
            r_lo    <= i_lo;
            r_hi    <= i_hi;
        end
        r_idx  <= n_idx;
        r_pend <= n_pend;
        if (i_cmd.st_load) begin
            r_status <= i_cmd.st_val;
        end
        if (i_cmd.emit) begin
            r_o_status <= r_status;
            r_o_match  <= r_pend_valid;
            r_o_key    <= r_pend_valid ? r_pend[DW-1:HANDLE_BITS] : '0;
            r_o_child  <= r_pend_valid ? r_pend[HANDLE_BITS-1:0] : '0;
            r_o_last   <= i_cmd.emit_last;
            r_o_count  <= r_count;
            r_o_full   <= w_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end
            r_pend_valid <= n_pend_valid;
            if (i_cmd.emit) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.full       = w_full;
        o_stat.count_zero = (r_count == '0);
        o_stat.idx_zero   = (r_idx == '0);
        o_stat.idx_one    = (r_idx == IW'(1));
        o_stat.idx_last   = (r_idx == w_cnt_m1[IW-1:0]);
        o_stat.key_ge     = (w_rd_key >= r_key);
        o_stat.key_eq     = (w_rd_key == r_key);
        o_stat.below_lo   = (w_rd_key < r_lo);
        o_stat.above_hi   = (w_rd_key > r_hi);
        o_stat.pend_valid = r_pend_valid;
        o_stat.out_free   = w_out_free;
        o_stat.is_replace = (r_func == sct_pkg::FN_REPLACE);
    end

    assign o_out_valid = r_o_valid;
    assign o_status    = r_o_status;
    assign o_match     = r_o_match;
    assign o_key       = r_o_key;
    assign o_child     = r_o_child;
    assign o_last      = r_o_last;
    assign o_count     = r_o_count;
    assign o_full      = r_o_full;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> w_out_free)
        else $error("result written over an untaken result");

    a_inc_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_inc |-> !w_full)
        else $error("insert completed into a full table");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_inc |=> r_count == $past(r_count) + CW'(1))
        else $error("entry count did not step once on insert");

endmodule

`default_nettype wire

>>> design/sorted_sixteen_entry_child_table.sv
// Top level of the sorted child table: controller, datapath and channel hookup.
//
// The block keeps up to CAPACITY entries (a key byte and a child handle) in
// ascending key order. Requests arrive on i_req and each transfer carries one
// operation: insert, lookup, replace child or range scan. Results leave on
// o_rsp; every request gives exactly one result, except a range scan, which
// gives one per matching entry from the highest key down, with last set on
// the final one (or a single empty result when nothing matches).
// Sequence: a request is first accepted, then the walk visits the slots it
// needs, then the result register is loaded. The walk visits one slot per
// cycle, set by the single read port of the entry RAM, unless a stalled
// receiver holds a scan.
// A new request is taken as soon as the previous result sits in the output
// register, so a stalled receiver holds back only the next result, not the
// next transfer. During a scan a stalled receiver freezes the walk.
// Reset clears the entry count and the channel state; the RAM contents are
// left as they are, since only slots below the count are ever read.
`default_nettype none

module sorted_sixteen_entry_child_table #(
    parameter int CAPACITY    = sct_pkg::CAPACITY,
    parameter int HANDLE_BITS = sct_pkg::HANDLE_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sct_req_if.sink    i_req,
    sct_rsp_if.source  o_rsp
);

    // Controller and datapath talk only through these two groups.
    sct_pkg::t_cmd  w_cmd;
    sct_pkg::t_stat w_stat;
    logic           w_req_ready;

    sct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_func  (i_req.func),
        .o_req_ready (w_req_ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    assign i_req.ready = w_req_ready;

    // The datapath owns the output register, so the result channel is driven
    // straight from flops.
    sct_datapath #(
        .CAPACITY    (CAPACITY),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_func      (i_req.func),
        .i_key       (i_req.key_in),
        .i_child     (i_req.child_handle),
        .i_lo        (i_req.range_low),
        .i_hi        (i_req.range_high),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .o_status    (o_rsp.status),
        .o_match     (o_rsp.match_valid),
        .o_key       (o_rsp.key_out),
        .o_child     (o_rsp.child_out),
        .o_last      (o_rsp.last),
        .o_count     (o_rsp.entry_count),
        .o_full      (o_rsp.is_full)
    );

endmodule

`default_nettype wire

>>> tb/sorted_sixteen_entry_child_table_tb.sv
// Self-checking testbench of the sorted sixteen-entry child table.
`timescale 1ns / 1ps

module sorted_sixteen_entry_child_table_tb;

    typedef struct {
        sct_pkg::t_func                  func;
        logic [sct_pkg::KEY_BITS-1:0]    key;
        logic [sct_pkg::HANDLE_BITS-1:0] child;
        logic [sct_pkg::KEY_BITS-1:0]    lo;
        logic [sct_pkg::KEY_BITS-1:0]    hi;
    } t_table_request;

    typedef struct {
        sct_pkg::t_status                status;
        logic                            match_valid;
        logic [sct_pkg::KEY_BITS-1:0]    key;
        logic [sct_pkg::HANDLE_BITS-1:0] child;
        logic                            last;
        logic [sct_pkg::COUNT_BITS-1:0]  count;
        logic                            full;
    } t_table_result;

    // Keeps its own copy of the sorted table and the queue of results that
    // the accepted requests still owe.
    class t_table_scoreboard;
        logic [sct_pkg::KEY_BITS-1:0]    key_slot [sct_pkg::CAPACITY];
        logic [sct_pkg::HANDLE_BITS-1:0] child_slot [sct_pkg::CAPACITY];
        int                              entries;
        t_table_result                   awaited [$];
        int                              error_count;

        function new();
            entries     = 0;
            error_count = 0;
        endfunction

        function void push_result(sct_pkg::t_status status, logic valid,
                                  logic [sct_pkg::KEY_BITS-1:0] key,
                                  logic [sct_pkg::HANDLE_BITS-1:0] child, logic last);
            t_table_result res;
            res.status      = status;
            res.match_valid = valid;
            res.key         = valid ? key : '0;
            res.child       = valid ? child : '0;
            res.last        = last;
            res.count       = sct_pkg::COUNT_BITS'(entries);
            res.full        = (entries >= sct_pkg::CAPACITY);
            awaited.push_back(res);
        endfunction

        // Applies one accepted request to the table and queues its results.
        function void note_request(t_table_request rq);
            int slot;
            int j;
            int hits;
            unique case (rq.func)
                sct_pkg::FN_INSERT: begin
                    if (entries >= sct_pkg::CAPACITY) begin
                        push_result(sct_pkg::ST_FULL, 1'b0, '0, '0, 1'b1);
                    end else begin
                        // A duplicate lands in front of the equal keys.
                        slot = 0;
                        while (slot < entries && rq.key > key_slot[slot]) slot++;
                        for (j = entries; j > slot; j--) begin
                            key_slot[j]   = key_slot[j-1];
                            child_slot[j] = child_slot[j-1];
                        end
                        key_slot[slot]   = rq.key;
                        child_slot[slot] = rq.child;
                        entries++;
                        push_result(sct_pkg::ST_OK, 1'b0, '0, '0, 1'b1);
                    end
                end
                sct_pkg::FN_LOOKUP, sct_pkg::FN_REPLACE: begin
                    slot = -1;
                    for (j = 0; j < entries; j++) begin
                        if (key_slot[j] == rq.key) begin
                            slot = j;
                            break;
                        end
                    end
                    if (slot < 0) begin
                        push_result(sct_pkg::ST_NOT_FOUND, 1'b0, '0, '0, 1'b1);
                    end else begin
                        if (rq.func == sct_pkg::FN_REPLACE) child_slot[slot] = rq.child;
                        push_result(sct_pkg::ST_OK, 1'b1, key_slot[slot], child_slot[slot],
                                    1'b1);
                    end
                end
                sct_pkg::FN_SCAN: begin
                    // Walk down from the top slot; the first key below the
                    // lower bound ends the walk.
                    hits = 0;
                    for (j = entries - 1; j >= 0; j--) begin
                        if (key_slot[j] < rq.lo) break;
                        if (key_slot[j] <= rq.hi) begin
                            push_result(sct_pkg::ST_OK, 1'b1, key_slot[j], child_slot[j],
                                        1'b0);
                            hits++;
                        end
                    end
                    if (hits == 0) push_result(sct_pkg::ST_OK, 1'b0, '0, '0, 1'b1);
                    else awaited[awaited.size()-1].last = 1'b1;
                end
            endcase
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
            if (seen !== want) begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, seen);
                error_count++;
            end
        endfunction

        function void check_result(t_table_result got);
            t_table_result want;
            if (awaited.size() == 0) begin
                $error("result with nothing awaited: status=%0d key=0x%0h child=0x%0h",
                       got.status, got.key, got.child);
                error_count++;
                return;
            end
            want = awaited.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("match_valid", want.match_valid, got.match_valid);
            compare_field("key_out", want.key, got.key);
            compare_field("child_out", want.child, got.child);
            compare_field("last", want.last, got.last);
            compare_field("entry_count", want.count, got.count);
            compare_field("is_full", want.full, got.full);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   sender_calm;
    t_table_scoreboard table_sb;

    sct_req_if req_if ();
    sct_rsp_if rsp_if ();

    sorted_sixteen_entry_child_table i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #5 clk = ~clk;

    // Mostly short gaps, now and then a long one, none at all while calm.
    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic t_table_request make_request(sct_pkg::t_func func,
                                                    logic [sct_pkg::KEY_BITS-1:0] key,
                                                    logic [sct_pkg::HANDLE_BITS-1:0] child,
                                                    logic [sct_pkg::KEY_BITS-1:0] lo,
                                                    logic [sct_pkg::KEY_BITS-1:0] hi);
        t_table_request rq;
        rq.func  = func;
        rq.key   = key;
        rq.child = child;
        rq.lo    = lo;
        rq.hi    = hi;
        return rq;
    endfunction

    // Presents one request from a falling edge and holds it until a rising
    // edge sees the transfer; valid stays high when no gap follows.
    task automatic send_request(t_table_request rq);
        int gap;
        @(negedge clk);
        req_if.valid        = 1'b1;
        req_if.func         = rq.func;
        req_if.key_in       = rq.key;
        req_if.child_handle = rq.child;
        req_if.range_low    = rq.lo;
        req_if.range_high   = rq.hi;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        table_sb.note_request(rq);
        if ($urandom_range(0, 29) == 0) sender_calm = !sender_calm;
        gap = pick_gap(sender_calm);
        if (gap > 0) begin
            @(negedge clk);
            req_if.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Holds the request side idle until every awaited result has come back.
    task automatic drain_results();
        @(negedge clk);
        req_if.valid = 1'b0;
        while (table_sb.awaited.size() != 0) @(posedge clk);
    endtask

    // Result side: check at the rising edge, move ready at the falling edge.
    initial begin : result_sink
        int stall_left;
        bit calm;
        t_table_result got;
        stall_left   = 0;
        calm         = 1'b0;
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && rsp_if.valid && rsp_if.ready) begin
                got.status      = sct_pkg::t_status'(rsp_if.status);
                got.match_valid = rsp_if.match_valid;
                got.key         = rsp_if.key_out;
                got.child       = rsp_if.child_out;
                got.last        = rsp_if.last;
                got.count       = rsp_if.entry_count;
                got.full        = rsp_if.is_full;
                table_sb.check_result(got);
            end
            @(negedge clk);
            if ($urandom_range(0, 99) == 0) calm = !calm;
            if (!rst_n) begin
                rsp_if.ready = 1'b0;
            end else if (stall_left > 0) begin
                rsp_if.ready = 1'b0;
                stall_left--;
            end else begin
                stall_left   = ($urandom_range(0, 3) == 0) ? pick_gap(calm) : 0;
                rsp_if.ready = (stall_left == 0);
            end
        end
    end

    initial begin : stimulus
        t_table_request rq;
        int n;
        int r;
        logic [sct_pkg::KEY_BITS-1:0] tmp;

        table_sb            = new();
        sender_calm         = 1'b0;
        rst_n               = 1'b0;
        req_if.valid        = 1'b0;
        req_if.func         = sct_pkg::FN_INSERT;
        req_if.key_in       = '0;
        req_if.child_handle = '0;
        req_if.range_low    = '0;
        req_if.range_high   = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty table: misses and an empty scan.
        send_request(make_request(sct_pkg::FN_LOOKUP, 8'h00, '0, 8'h00, 8'hFF));
        send_request(make_request(sct_pkg::FN_REPLACE, 8'hFF, '1, 8'h00, 8'hFF));
        send_request(make_request(sct_pkg::FN_SCAN, 8'h00, '0, 8'h00, 8'hFF));
        // Extreme keys and handles, then a duplicate that must win lookups.
        send_request(make_request(sct_pkg::FN_INSERT, 8'h80, '1, 8'h00, 8'h00));
        send_request(make_request(sct_pkg::FN_INSERT, 8'h00, '0, 8'hFF, 8'hFF));
        send_request(make_request(sct_pkg::FN_INSERT, 8'hFF, 48'hAAAA_AAAA_AAAA,
                                  8'h00, 8'h00));
        send_request(make_request(sct_pkg::FN_INSERT, 8'h80, 48'h5555_5555_5555,
                                  8'h00, 8'h00));
        send_request(make_request(sct_pkg::FN_LOOKUP, 8'h80, '0, 8'h00, 8'h00));
        send_request(make_request(sct_pkg::FN_REPLACE, 8'h80, 48'h1234_5678_9ABC,
                                  8'h00, 8'h00));
        send_request(make_request(sct_pkg::FN_LOOKUP, 8'h7F, '0, 8'h00, 8'h00));
        send_request(make_request(sct_pkg::FN_SCAN, 8'h00, '0, 8'h00, 8'hFF));
        // Inverted bounds match nothing; a tight window stops on the low key.
        send_request(make_request(sct_pkg::FN_SCAN, 8'h00, '0, 8'h81, 8'h7F));
        send_request(make_request(sct_pkg::FN_SCAN, 8'h00, '0, 8'h80, 8'h80));
        // Fill up, with some duplicates, then hit the full table.
        while (table_sb.entries < sct_pkg::CAPACITY) begin
            rq = make_request(sct_pkg::FN_INSERT, 8'($urandom_range(0, 255)),
                              sct_pkg::HANDLE_BITS'({$urandom(), $urandom()}),
                              8'h00, 8'h00);
            if ($urandom_range(0, 3) == 0)
                rq.key = table_sb.key_slot[$urandom_range(0, table_sb.entries - 1)];
            send_request(rq);
        end
        send_request(make_request(sct_pkg::FN_INSERT, 8'h42, '1, 8'h00, 8'h00));
        send_request(make_request(sct_pkg::FN_SCAN, 8'h00, '0, 8'h00, 8'hFF));
        drain_results();

        // Random part: keys mostly taken from the table so that hits and
        // narrow scans dominate; the rest is random noise.
        for (n = 0; n < 300; n++) begin
            rq.key   = 8'($urandom_range(0, 255));
            rq.child = sct_pkg::HANDLE_BITS'({$urandom(), $urandom()});
            rq.lo    = 8'($urandom_range(0, 255));
            rq.hi    = 8'($urandom_range(0, 255));
            r = $urandom_range(0, 99);
            if (r < 10) rq.func = sct_pkg::FN_INSERT;
            else if (r < 45) rq.func = sct_pkg::FN_LOOKUP;
            else if (r < 70) rq.func = sct_pkg::FN_REPLACE;
            else rq.func = sct_pkg::FN_SCAN;
            r = $urandom_range(0, 9);
            if (rq.func == sct_pkg::FN_LOOKUP || rq.func == sct_pkg::FN_REPLACE) begin
                if (r < 7) rq.key = table_sb.key_slot[$urandom_range(0, table_sb.entries - 1)];
                if (r == 7) rq.child = '1;
                if (r == 8) rq.child = '0;
            end else if (rq.func == sct_pkg::FN_SCAN && r > 1) begin
                rq.lo = table_sb.key_slot[$urandom_range(0, table_sb.entries - 1)]
                        - 8'($urandom_range(0, 2));
                rq.hi = table_sb.key_slot[$urandom_range(0, table_sb.entries - 1)];
                if (rq.lo > rq.hi) begin
                    tmp   = rq.lo;
                    rq.lo = rq.hi;
                    rq.hi = tmp;
                end
            end else if (rq.func == sct_pkg::FN_SCAN && r == 0) begin
                rq.lo = 8'h00;
                rq.hi = 8'hFF;
            end
            send_request(rq);
            if (n % 100 == 99) drain_results();
        end

        drain_results();
        repeat (40) @(posedge clk);
        if (table_sb.awaited.size() != 0) begin
            $error("%0d results never arrived", table_sb.awaited.size());
            table_sb.error_count++;
        end
        if (table_sb.error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin : watchdog
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
design/sct_pkg.sv
design/sct_if.sv
design/sct_ram.sv
design/sct_ctrl.sv
design/sct_datapath.sv
design/sorted_sixteen_entry_child_table.sv
tb/sorted_sixteen_entry_child_table_tb.sv
